FILE: rtl/rflfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rflfd_pkg
// shared types, command codes and helpers for the radio lighting frame decoder
// ----------------------------------------------------------------------------
package rflfd_pkg;

    // command byte codes
    localparam logic [7:0] CMD_ON      = 8'h20;
    localparam logic [7:0] CMD_CHASE   = 8'h40;
    localparam logic [7:0] CMD_UNLOCK  = 8'h60;
    localparam logic [7:0] CMD_BREATH  = 8'h80;
    localparam logic [7:0] CMD_CHANNEL = 8'hA0;
    localparam logic [7:0] CMD_BLINK   = 8'hB0;
    localparam logic [7:0] CMD_READDR  = 8'hC0;
    localparam logic [7:0] CMD_RAINBOW = 8'hD0;
    localparam logic [7:0] CMD_SOLID   = 8'hE0;
    localparam logic [7:0] CMD_SNOW    = 8'hF0;

    // frame status codes
    localparam logic [1:0] ST_BAD_SUM = 2'd0;
    localparam logic [1:0] ST_CHANNEL = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_NEW     = 2'd3;

    // phase action codes
    localparam logic [1:0] PH_KEEP  = 2'd0;
    localparam logic [1:0] PH_CLEAR = 2'd1;
    localparam logic [1:0] PH_FADE  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_OFF_COLOR   = 3'd0;
    localparam logic [2:0] REG_MODE_OFF    = 3'd1;
    localparam logic [2:0] REG_MODE_ON     = 3'd2;
    localparam logic [2:0] REG_MODE_FADING = 3'd3;
    localparam logic [2:0] REG_MODE_QUICK  = 3'd4;
    localparam logic [2:0] REG_MODE_STROBE = 3'd5;

    // blink sub-modes: two pick the quick code, one picks the solid on code
    localparam logic [3:0] BLINK_QUICK_A = 4'd4;
    localparam logic [3:0] BLINK_QUICK_B = 4'd5;
    localparam logic [1:0] BLINK_SOLID   = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int NODE_ADDR_MAX = 16;

    typedef enum logic [3:0] {
        K_ON,
        K_CHASE,
        K_UNLOCK,
        K_BREATH,
        K_CHANNEL,
        K_BLINK,
        K_READDR,
        K_RAINBOW,
        K_SOLID,
        K_SNOW,
        K_OTHER
    } cmd_kind_t;

    typedef struct packed {
        logic [3:0] off_color;
        logic [3:0] mode_off;
        logic [3:0] mode_on;
        logic [3:0] mode_fading;
        logic [3:0] mode_quick;
        logic [3:0] mode_strobe;
    } cfg_t;

    // classified frame as it travels from front to back
    typedef struct packed {
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [31:0] frame;
        logic [3:0]  color;
        logic [3:0]  mode;
        logic [3:0]  slot;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        sum_ok;
        cmd_kind_t   kind;
    } frame_item_t;

    typedef struct packed {
        logic [1:0] frame_status;
        logic       key_lock;
        logic [3:0] light_color;
        logic [3:0] light_mode;
        logic [1:0] phase_action;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [3:0] breath_kind;
        logic       quick_blink;
        logic       random_hit;
        logic [4:0] logical_address;
    } result_t;

    // remainder by ten of a value below 32
    function automatic logic [3:0] mod10(input logic [4:0] v);
        logic [4:0] r;
        if (v >= 5'd30)
        begin
            r = v - 5'd30;
        end
        else if (v >= 5'd20)
        begin
            r = v - 5'd20;
        end
        else if (v >= 5'd10)
        begin
            r = v - 5'd10;
        end
        else
        begin
            r = v;
        end
        return r[3:0];
    endfunction

    // duty level from a nibble, scaled by 17
    function automatic logic [7:0] duty_of(input logic [3:0] n);
        return {n, n};
    endfunction

endpackage

FILE: rtl/rf_lighting_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_lighting_frame_decoder
// decodes five-byte radio lighting frames into led control state
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              contents
//  -------   ---------  ---------------------  ----------------------------------
//  in        sink       in_valid / in_stall    frame bytes 0..4 and random slot
//  out       source     out_valid / out_stall  status, lock, color, mode, duties
//  apb       slave      psel/penable/pready    six 4-bit code registers
//
//  one transaction per clock sustained while out_stall stays low; the accepted
//  frame is written into the queue and then executed from the queue head into
//  the output reg, where it shows up; the front checks the sum and decodes the
//  command with no node state; a two-entry queue absorbs output stalls, and
//  the front waits only on in_stall, which rises only when the queue is full
//  rst_n resets all node state (node address to 1), clears the queue and the
//  output valid, and loads the code registers with their defaults
//
module rf_lighting_frame_decoder
    import rflfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // frame input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  addr_mask_low,
    input  logic [7:0]  addr_mask_high,
    input  logic [7:0]  param_byte,
    input  logic [7:0]  command_byte,
    input  logic [7:0]  check_byte,
    input  logic [3:0]  random_slot,

    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  frame_status,
    output logic        key_lock,
    output logic [3:0]  light_color,
    output logic [3:0]  light_mode,
    output logic [1:0]  phase_action,
    output logic [7:0]  red_level,
    output logic [7:0]  green_level,
    output logic [7:0]  blue_level,
    output logic [3:0]  breath_kind,
    output logic        quick_blink,
    output logic        random_hit,
    output logic [4:0]  logical_address
);

    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic [2:0]  reg_idx;
    logic [3:0]  rd_nib;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_not_empty;
    frame_item_t front_item;
    frame_item_t head_item;
    result_t     res;

    // ------------------------------------------------------------------
    // code registers, one per word; writes beyond the list are dropped
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.off_color   <= 4'd0;
            cfg_reg.mode_off    <= 4'd0;
            cfg_reg.mode_on     <= 4'd1;
            cfg_reg.mode_fading <= 4'd2;
            cfg_reg.mode_quick  <= 4'd3;
            cfg_reg.mode_strobe <= 4'd4;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_OFF_COLOR:   cfg_reg.off_color   <= pwdata[3:0];
                REG_MODE_OFF:    cfg_reg.mode_off    <= pwdata[3:0];
                REG_MODE_ON:     cfg_reg.mode_on     <= pwdata[3:0];
                REG_MODE_FADING: cfg_reg.mode_fading <= pwdata[3:0];
                REG_MODE_QUICK:  cfg_reg.mode_quick  <= pwdata[3:0];
                REG_MODE_STROBE: cfg_reg.mode_strobe <= pwdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back, zero for unmapped words
    always_comb
    begin
        case (reg_idx)
            REG_OFF_COLOR:   rd_nib = cfg_reg.off_color;
            REG_MODE_OFF:    rd_nib = cfg_reg.mode_off;
            REG_MODE_ON:     rd_nib = cfg_reg.mode_on;
            REG_MODE_FADING: rd_nib = cfg_reg.mode_fading;
            REG_MODE_QUICK:  rd_nib = cfg_reg.mode_quick;
            REG_MODE_STROBE: rd_nib = cfg_reg.mode_strobe;
            default:         rd_nib = 4'd0;
        endcase
    end

    assign prdata = {28'd0, rd_nib};

    // ------------------------------------------------------------------
    // front: sum check and command decode
    // ------------------------------------------------------------------
    rflfd_front u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .addr_mask_low  (addr_mask_low),
        .addr_mask_high (addr_mask_high),
        .param_byte     (param_byte),
        .command_byte   (command_byte),
        .check_byte     (check_byte),
        .random_slot    (random_slot),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (front_item)
    );

    // ------------------------------------------------------------------
    // decoupling queue
    // ------------------------------------------------------------------
    rflfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // ------------------------------------------------------------------
    // back: node state update and output register
    // ------------------------------------------------------------------
    rflfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (res)
    );

    assign frame_status    = res.frame_status;
    assign key_lock        = res.key_lock;
    assign light_color     = res.light_color;
    assign light_mode      = res.light_mode;
    assign phase_action    = res.phase_action;
    assign red_level       = res.red_level;
    assign green_level     = res.green_level;
    assign blue_level      = res.blue_level;
    assign breath_kind     = res.breath_kind;
    assign quick_blink     = res.quick_blink;
    assign random_hit      = res.random_hit;
    assign logical_address = res.logical_address;

endmodule

FILE: rtl/rflfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rflfd_front
// accepts frames, checks the sum and decodes the command into a queue entry
// ----------------------------------------------------------------------------
module rflfd_front
    import rflfd_pkg::*;
(
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  addr_mask_low,
    input  logic [7:0]  addr_mask_high,
    input  logic [7:0]  param_byte,
    input  logic [7:0]  command_byte,
    input  logic [7:0]  check_byte,
    input  logic [3:0]  random_slot,
    input  logic        q_full,
    output logic        q_push,
    output frame_item_t q_item
);

    logic [7:0] sum8;
    cmd_kind_t  kind;

    assign sum8 = addr_mask_low + addr_mask_high + param_byte + command_byte;

    always_comb
    begin
        case (command_byte)
            CMD_ON:      kind = K_ON;
            CMD_CHASE:   kind = K_CHASE;
            CMD_UNLOCK:  kind = K_UNLOCK;
            CMD_BREATH:  kind = K_BREATH;
            CMD_CHANNEL: kind = K_CHANNEL;
            CMD_BLINK:   kind = K_BLINK;
            CMD_READDR:  kind = K_READDR;
            CMD_RAINBOW: kind = K_RAINBOW;
            CMD_SOLID:   kind = K_SOLID;
            CMD_SNOW:    kind = K_SNOW;
            default:     kind = K_OTHER;
        endcase
    end

    assign in_stall = q_full;
    assign q_push   = in_valid & ~q_full;

    always_comb
    begin
        q_item.b0     = addr_mask_low;
        q_item.b1     = addr_mask_high;
        q_item.frame  = {command_byte, param_byte, addr_mask_high, addr_mask_low};
        q_item.color  = param_byte[7:4];
        q_item.mode   = param_byte[3:0];
        q_item.slot   = random_slot;
        q_item.red    = duty_of(addr_mask_high[3:0]);
        q_item.green  = duty_of(param_byte[7:4]);
        q_item.blue   = duty_of(param_byte[3:0]);
        q_item.sum_ok = (sum8 == check_byte);
        q_item.kind   = kind;
    end

endmodule

FILE: rtl/rflfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rflfd_queue
// short fifo of classified frames between front and back
// ----------------------------------------------------------------------------
module rflfd_queue
    import rflfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_item_t push_item,
    input  logic        pop,
    output logic        full,
    output logic        not_empty,
    output frame_item_t head_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    frame_item_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/rflfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rflfd_back
// executes classified frames against the node state and registers the result
// ----------------------------------------------------------------------------
module rflfd_back
    import rflfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_not_empty,
    input  frame_item_t q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output result_t     out_data
);

    logic [4:0]  node_address_reg, node_address_next;
    logic        lock_flag_reg, lock_flag_next;
    logic        chase_active_reg, chase_active_next;
    logic        last_valid_reg, last_valid_next;
    logic [31:0] last_frame_reg, last_frame_next;
    logic [3:0]  saved_color_reg, saved_color_next;
    logic        snow_active_reg, snow_active_next;
    logic [1:0]  snow_count_reg, snow_count_next;
    logic [3:0]  color_reg, color_next;
    logic [3:0]  mode_reg, mode_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic        quick_reg, quick_next;
    logic        random_reg, random_next;
    logic [3:0]  breath_reg, breath_next;
    logic        out_valid_reg;
    result_t     out_data_reg;

    logic [1:0]  status;
    logic [1:0]  phase;
    logic [4:0]  addr_m1;
    logic [15:0] sel_bits;
    logic        sel;
    logic        addr_hit;
    logic [4:0]  rainbow_sum;
    logic        snow_hit;
    logic [1:0]  snow_cnt_inc;
    logic [3:0]  ch_mode;
    result_t     result;

    assign q_pop = q_not_empty & (~out_valid_reg | ~out_stall);

    // node select from the address masks
    assign addr_m1  = node_address_reg - 5'd1;
    assign sel_bits = {q_item.b1, q_item.b0};
    assign sel      = (node_address_reg >= 5'd1) &&
                      (node_address_reg <= 5'(NODE_ADDR_MAX)) &&
                      sel_bits[addr_m1[3:0]];
    assign addr_hit = (q_item.b0 == {3'b000, node_address_reg});

    assign rainbow_sum  = {1'b0, q_item.color} + node_address_reg;
    assign snow_hit     = (q_item.mode == q_item.slot) && !snow_active_reg;
    assign snow_cnt_inc = (snow_hit ? 2'd0 : snow_count_reg) + 2'd1;
    assign ch_mode      = q_item.b1[7:4];

    always_comb
    begin
        node_address_next = node_address_reg;
        lock_flag_next    = lock_flag_reg;
        chase_active_next = chase_active_reg;
        last_valid_next   = last_valid_reg;
        last_frame_next   = last_frame_reg;
        saved_color_next  = saved_color_reg;
        snow_active_next  = snow_active_reg;
        snow_count_next   = snow_count_reg;
        color_next        = color_reg;
        mode_next         = mode_reg;
        red_next          = red_reg;
        green_next        = green_reg;
        blue_next         = blue_reg;
        quick_next        = quick_reg;
        random_next       = random_reg;
        breath_next       = breath_reg;
        status            = ST_BAD_SUM;
        phase             = PH_KEEP;

        if (q_item.sum_ok)
        begin
            // key lock and chase tracking apply to every good frame
            if (q_item.kind != K_UNLOCK)
            begin
                if (q_item.kind == K_RAINBOW || q_item.kind == K_SNOW ||
                    (q_item.kind == K_CHANNEL && addr_hit))
                begin
                    lock_flag_next = 1'b1;
                end
                else if (sel && (q_item.kind inside
                         {K_ON, K_CHASE, K_BREATH, K_BLINK, K_READDR, K_SOLID}))
                begin
                    lock_flag_next = 1'b1;
                end
            end
            if (q_item.kind != K_CHASE)
            begin
                chase_active_next = 1'b0;
            end

            if (q_item.kind == K_CHANNEL)
            begin
                status      = ST_CHANNEL;
                random_next = 1'b0;
                if (q_item.b0 == 8'd0)
                begin
                    phase = PH_CLEAR;
                end
                else if (addr_hit)
                begin
                    mode_next  = ch_mode;
                    color_next = cfg.off_color;
                    if (ch_mode == cfg.mode_off)
                    begin
                        phase      = PH_CLEAR;
                        red_next   = 8'd0;
                        green_next = 8'd0;
                        blue_next  = 8'd0;
                    end
                    else
                    begin
                        if (ch_mode == cfg.mode_on)
                        begin
                            phase = PH_CLEAR;
                        end
                        red_next   = q_item.red;
                        green_next = q_item.green;
                        blue_next  = q_item.blue;
                    end
                end
            end
            else if (last_valid_reg && (last_frame_reg == q_item.frame))
            begin
                status = ST_DUP;
            end
            else
            begin
                status          = ST_NEW;
                last_frame_next = q_item.frame;
                last_valid_next = 1'b1;
                random_next     = 1'b0;
                case (q_item.kind)
                    K_ON:
                    begin
                        if (sel)
                        begin
                            color_next = q_item.color;
                            mode_next  = q_item.mode;
                            phase      = PH_CLEAR;
                            quick_next = 1'b0;
                            if (q_item.color != cfg.off_color)
                            begin
                                saved_color_next = q_item.color;
                            end
                        end
                    end
                    K_CHASE:
                    begin
                        if (!chase_active_reg)
                        begin
                            chase_active_next = 1'b1;
                            phase             = PH_CLEAR;
                        end
                        mode_next  = q_item.mode;
                        color_next = (sel && q_item.color != cfg.off_color) ?
                                     q_item.color : cfg.off_color;
                    end
                    K_UNLOCK:
                    begin
                        if (sel)
                        begin
                            lock_flag_next = 1'b0;
                            color_next     = q_item.color;
                            mode_next      = q_item.mode;
                            phase          = PH_CLEAR;
                        end
                    end
                    K_BREATH:
                    begin
                        if (sel)
                        begin
                            color_next  = q_item.color;
                            breath_next = q_item.mode;
                            phase       = PH_FADE;
                            mode_next   = cfg.mode_fading;
                        end
                    end
                    K_BLINK:
                    begin
                        if (sel)
                        begin
                            phase = PH_CLEAR;
                            if (q_item.mode[1:0] == BLINK_SOLID)
                            begin
                                quick_next = 1'b0;
                                color_next = cfg.off_color;
                                mode_next  = cfg.mode_on;
                            end
                            else if (q_item.mode == BLINK_QUICK_A ||
                                     q_item.mode == BLINK_QUICK_B)
                            begin
                                quick_next = 1'b1;
                                color_next = saved_color_reg;
                                mode_next  = cfg.mode_quick;
                            end
                            else
                            begin
                                quick_next = 1'b1;
                                color_next = saved_color_reg;
                                mode_next  = cfg.mode_strobe;
                            end
                        end
                    end
                    K_READDR:
                    begin
                        if (sel)
                        begin
                            node_address_next = {1'b0, q_item.mode} + 5'd1;
                        end
                    end
                    K_RAINBOW:
                    begin
                        color_next = mod10(rainbow_sum) + 4'd1;
                        mode_next  = q_item.mode;
                        phase      = PH_CLEAR;
                    end
                    K_SOLID:
                    begin
                        if (sel)
                        begin
                            quick_next = 1'b0;
                            color_next = q_item.color;
                            mode_next  = cfg.mode_on;
                            phase      = PH_CLEAR;
                        end
                    end
                    K_SNOW:
                    begin
                        if (snow_hit)
                        begin
                            random_next = 1'b1;
                            color_next  = q_item.color;
                            mode_next   = cfg.mode_on;
                        end
                        if (snow_hit || snow_active_reg)
                        begin
                            // the effect ends on its third frame
                            if (snow_cnt_inc > 2'd2)
                            begin
                                snow_active_next = 1'b0;
                                snow_count_next  = 2'd0;
                                color_next       = cfg.off_color;
                                mode_next        = cfg.mode_off;
                            end
                            else
                            begin
                                snow_active_next = 1'b1;
                                snow_count_next  = snow_cnt_inc;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result.frame_status    = status;
        result.key_lock        = lock_flag_next;
        result.light_color     = color_next;
        result.light_mode      = mode_next;
        result.phase_action    = phase;
        result.red_level       = red_next;
        result.green_level     = green_next;
        result.blue_level      = blue_next;
        result.breath_kind     = breath_next;
        result.quick_blink     = quick_next;
        result.random_hit      = random_next;
        result.logical_address = node_address_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= 5'd1;
            lock_flag_reg    <= 1'b0;
            chase_active_reg <= 1'b0;
            last_valid_reg   <= 1'b0;
            last_frame_reg   <= '0;
            saved_color_reg  <= '0;
            snow_active_reg  <= 1'b0;
            snow_count_reg   <= '0;
            color_reg        <= '0;
            mode_reg         <= '0;
            red_reg          <= '0;
            green_reg        <= '0;
            blue_reg         <= '0;
            quick_reg        <= 1'b0;
            random_reg       <= 1'b0;
            breath_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                node_address_reg <= node_address_next;
                lock_flag_reg    <= lock_flag_next;
                chase_active_reg <= chase_active_next;
                last_valid_reg   <= last_valid_next;
                last_frame_reg   <= last_frame_next;
                saved_color_reg  <= saved_color_next;
                snow_active_reg  <= snow_active_next;
                snow_count_reg   <= snow_count_next;
                color_reg        <= color_next;
                mode_reg         <= mode_next;
                red_reg          <= red_next;
                green_reg        <= green_next;
                blue_reg         <= blue_next;
                quick_reg        <= quick_next;
                random_reg       <= random_next;
                breath_reg       <= breath_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
